// ===== rtl/core/ftft_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the five-tuple flow table.
// No dependencies; imported by every module of the block.
package ftft_pkg;

    localparam logic [1:0] CMD_ADD      = 2'd0;
    localparam logic [1:0] CMD_REMOVE   = 2'd1;
    localparam logic [1:0] CMD_GET      = 2'd2;
    localparam logic [1:0] CMD_CLASSIFY = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  protocol;
        logic [31:0] flow_id;
        logic [2:0]  tclass;
    } t_ft_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] match_flow_id;
        logic [2:0]  class_out;
    } t_ft_out;

    // One stored slot: rule, flow id and class.
    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  protocol;
        logic [31:0] flow_id;
        logic [2:0]  tclass;
    } t_ft_entry;

endpackage

// ===== rtl/core/ftft_slot_mem.sv =====
`timescale 1ns / 1ps
// Slot storage: one write port, one registered read port.
// Depends on ftft_pkg for the entry type.
module ftft_slot_mem #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [IDX_W-1:0]         i_rd_addr,
    output ftft_pkg::t_ft_entry      o_rd_data,
    input  logic                     i_wr_en,
    input  logic [IDX_W-1:0]         i_wr_addr,
    input  ftft_pkg::t_ft_entry      i_wr_data
);
    import ftft_pkg::*;

    t_ft_entry r_mem [DEPTH];
    t_ft_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/ftft_match.sv =====
`timescale 1ns / 1ps
// Shared slot compare unit: decides whether one slot satisfies the command.
// Depends on ftft_pkg for command codes and types.
module ftft_match (
    input  ftft_pkg::t_ft_in    i_key,
    input  ftft_pkg::t_ft_entry i_entry,
    input  logic                i_slot_vld,
    output logic                o_hit
);
    import ftft_pkg::*;

    logic w_flow_eq;
    logic w_tuple_eq;

    assign w_flow_eq  = (i_entry.flow_id == i_key.flow_id);
    assign w_tuple_eq = (i_entry.src_ip == i_key.src_ip) &&
                        (i_entry.dst_ip == i_key.dst_ip) &&
                        (i_entry.sport == i_key.sport) &&
                        (i_entry.dport == i_key.dport) &&
                        (i_entry.protocol == i_key.protocol);

    always_comb begin
        case (i_key.cmd)
            CMD_ADD:      o_hit = !i_slot_vld;
            CMD_REMOVE:   o_hit = i_slot_vld && w_flow_eq;
            CMD_GET:      o_hit = i_slot_vld && w_flow_eq;
            CMD_CLASSIFY: o_hit = i_slot_vld && w_tuple_eq;
            default:      o_hit = 1'b0;
        endcase
    end

endmodule

// ===== rtl/core/five_tuple_flow_table.sv =====
`timescale 1ns / 1ps
// Five-tuple flow table: slots are scanned one per cycle through one compare unit.
// Steps: a command is taken in idle; the scan issues one registered slot read at a time and
// compares it; the first hit or the last slot registers the result, which then waits in
// hold until the output register is free. The input stalls from the transfer until the
// result has moved to the output, so one command is in flight at a time.
// Reset clears every valid mark at once; slot contents are not cleared.
module five_tuple_flow_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ftft_pkg::t_ft_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ftft_pkg::t_ft_out o_out_data
);
    import ftft_pkg::*;

    localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } t_state;

    t_state                 r_state, n_state;
    t_ft_in                 r_key, n_key;
    logic [IdxW-1:0]        r_idx, n_idx;
    logic                   r_issue, n_issue;
    logic                   r_chk_vld, n_chk_vld;
    logic [IdxW-1:0]        r_chk_idx, n_chk_idx;
    logic                   r_chk_last, n_chk_last;
    logic [TABLE_DEPTH-1:0] r_slot_valid, n_slot_valid;
    t_ft_out                r_res, n_res;
    logic                   r_out_valid, n_out_valid;
    t_ft_out                r_out, n_out;

    t_ft_entry w_rd_entry;
    t_ft_entry w_wr_entry;
    logic      w_wr_en;
    logic      w_rd_en;
    logic      w_hit;

    assign w_rd_en = (r_state == S_SCAN) && r_issue;

    assign w_wr_entry = '{
        src_ip:   r_key.src_ip,
        dst_ip:   r_key.dst_ip,
        sport:    r_key.sport,
        dport:    r_key.dport,
        protocol: r_key.protocol,
        flow_id:  r_key.flow_id,
        tclass:   r_key.tclass
    };

    ftft_slot_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IdxW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_entry),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_chk_idx),
        .i_wr_data (w_wr_entry)
    );

    ftft_match u_match (
        .i_key      (r_key),
        .i_entry    (w_rd_entry),
        .i_slot_vld (r_slot_valid[r_chk_idx]),
        .o_hit      (w_hit)
    );

    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_idx        = r_idx;
        n_issue      = r_issue;
        n_chk_vld    = r_chk_vld;
        n_chk_idx    = r_chk_idx;
        n_chk_last   = r_chk_last;
        n_slot_valid = r_slot_valid;
        n_res        = r_res;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        w_wr_en      = 1'b0;

        // drop the output once it is taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key   = i_in_data;
                    n_idx   = '0;
                    n_issue = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // advance the read address; the compare runs in the cycle after each read
                if (r_issue) begin
                    n_chk_vld  = 1'b1;
                    n_chk_idx  = r_idx;
                    n_chk_last = (r_idx == LastIdx);
                    if (r_idx == LastIdx) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    n_chk_vld = 1'b0;
                end

                if (r_chk_vld && (w_hit || r_chk_last)) begin
                    n_chk_vld = 1'b0;
                    n_issue   = 1'b0;
                    n_state   = S_HOLD;
                    n_res     = '0;
                    if (w_hit) begin
                        n_res.status = ST_OK;
                        case (r_key.cmd)
                            CMD_ADD: begin
                                w_wr_en                 = 1'b1;
                                n_slot_valid[r_chk_idx] = 1'b1;
                            end
                            CMD_REMOVE: begin
                                n_slot_valid[r_chk_idx] = 1'b0;
                            end
                            CMD_GET: begin
                                n_res.class_out = w_rd_entry.tclass;
                            end
                            CMD_CLASSIFY: begin
                                n_res.match_flow_id = w_rd_entry.flow_id;
                            end
                            default: begin
                                n_res.status = ST_NOT_FOUND;
                            end
                        endcase
                    end else begin
                        n_res.status = (r_key.cmd == CMD_ADD) ? ST_FULL : ST_NOT_FOUND;
                    end
                end
            end
            S_HOLD: begin
                // hold the result until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_issue      <= 1'b0;
            r_chk_vld    <= 1'b0;
            r_slot_valid <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_issue      <= n_issue;
            r_chk_vld    <= n_chk_vld;
            r_slot_valid <= n_slot_valid;
            r_out_valid  <= n_out_valid;
        end
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_chk_idx  <= n_chk_idx;
        r_chk_last <= n_chk_last;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
